### rtl/seven_segment_number_formatter_defines.svh
// ----------------------------------------------------------------------------
// seven_segment_number_formatter_defines
// assertion macros shared by the formatter rtl
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_NUMBER_FORMATTER_DEFINES_SVH
`define SEVEN_SEGMENT_NUMBER_FORMATTER_DEFINES_SVH

// implication checked on every clock edge outside reset
`define SSNF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// check held on every clock edge, reset included
`define SSNF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### rtl/ssnf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssnf_pkg
// format codes, segment table and sizes for the number formatter
// ----------------------------------------------------------------------------
package ssnf_pkg;

    // format kinds
    localparam logic [1:0] KIND_HEX   = 2'd0;
    localparam logic [1:0] KIND_UDEC  = 2'd1;
    localparam logic [1:0] KIND_SDEC  = 2'd2;
    localparam logic [1:0] KIND_BLANK = 2'd3;

    // magnitude width fed to the bcd shifter (9999 fits in 14 bits)
    localparam int BIN_W = 14;
    localparam int BCD_W = 16;

    localparam logic [16:0] UMAX      = 17'd9999;
    localparam logic [13:0] SAT_POS   = 14'd9999;
    localparam logic [13:0] SAT_NEG   = 14'd999;
    localparam logic [7:0]  DOT_BIT   = 8'h80;
    localparam logic [7:0]  MINUS_RST = 8'h40;

    // hex digit to segment pattern, bits 0-6 are a-g
    function automatic logic [7:0] seg_of(input logic [3:0] nib);
        logic [7:0] s;
        case (nib)
            4'h0: s = 8'h3f;
            4'h1: s = 8'h06;
            4'h2: s = 8'h5b;
            4'h3: s = 8'h4f;
            4'h4: s = 8'h66;
            4'h5: s = 8'h6d;
            4'h6: s = 8'h7d;
            4'h7: s = 8'h07;
            4'h8: s = 8'h7f;
            4'h9: s = 8'h6f;
            4'ha: s = 8'h77;
            4'hb: s = 8'h7c;
            4'hc: s = 8'h39;
            4'hd: s = 8'h5e;
            4'he: s = 8'h79;
            default: s = 8'h71;
        endcase
        return s;
    endfunction

endpackage

### rtl/seven_segment_number_formatter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_number_formatter
// turns one number into four digit writes for a 4-digit 7-segment display
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Each request gives
// exactly four writes, one per cycle on consecutive cycles, each shown for a
// single cycle with o_valid; the receiver cannot stall them and must take
// every write as it comes. Hex and blank requests go straight to the output
// state; decimal requests first run a 14-step bit-serial binary-to-BCD
// shifter, one bit per cycle. Busy stays high until the last write is
// registered; that write is on the ports in the cycle the next request may
// be accepted. minus_pattern is to be written by the user through
// i_minus_we only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module seven_segment_number_formatter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_minus_we,
    input  logic [7:0]         i_minus_pattern,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_kind,
    input  logic signed [16:0] i_number,
    input  logic [2:0]         i_dot_position,
    output logic               o_valid,
    output logic [1:0]         o_digit_position,
    output logic [7:0]         o_segments,
    output logic               o_last,
    output logic               o_overflow
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_OUT
    } t_state;

    t_state                       r_state;
    logic [3:0]                   r_cnt;
    logic [ssnf_pkg::BIN_W-1:0]   r_bin;
    logic [ssnf_pkg::BCD_W-1:0]   r_bcd;
    logic [1:0]                   r_kind;
    logic [2:0]                   r_dot;
    logic                         r_neg;
    logic                         r_ovf;
    logic                         r_lead;
    logic [1:0]                   r_pos;
    logic [7:0]                   r_minus;
    logic                         r_valid;
    logic [1:0]                   r_out_pos;
    logic [7:0]                   r_seg;
    logic                         r_last;
    logic                         r_out_ovf;

    logic [ssnf_pkg::BIN_W-1:0]   n_mag;
    logic                         n_neg;
    logic                         n_ovf;
    logic [16:0]                  n_negated;
    logic [3:0]                   n_nib;
    logic [7:0]                   n_seg;
    logic                         n_lead;
    logic                         n_last;
    logic [ssnf_pkg::BCD_W-1:0]   n_dab;
    logic                         w_accept;

    // add three to every bcd digit of five or more before the shift
    function automatic logic [ssnf_pkg::BCD_W-1:0] dabble(
        input logic [ssnf_pkg::BCD_W-1:0] v
    );
        logic [ssnf_pkg::BCD_W-1:0] r;
        r = v;
        for (int i = 0; i < ssnf_pkg::BCD_W / 4; i++) begin
            if (v[4*i +: 4] >= 4'd5) begin
                r[4*i +: 4] = v[4*i +: 4] + 4'd3;
            end
        end
        return r;
    endfunction

    assign w_accept = start && !busy;
    assign busy     = (r_state != S_IDLE);
    assign n_dab    = dabble(r_bcd);

    // saturation and magnitude of the incoming number
    always_comb begin
        n_negated = 17'(-i_number);
        n_neg     = 1'b0;
        n_ovf     = 1'b0;
        n_mag     = i_number[ssnf_pkg::BIN_W-1:0];
        unique case (i_kind)
            ssnf_pkg::KIND_UDEC: begin
                if ($unsigned(i_number) > ssnf_pkg::UMAX) begin
                    n_ovf = 1'b1;
                    n_mag = ssnf_pkg::SAT_POS;
                end
            end
            ssnf_pkg::KIND_SDEC: begin
                if (i_number > 17'sd9999) begin
                    n_ovf = 1'b1;
                    n_mag = ssnf_pkg::SAT_POS;
                end else if (i_number < -17'sd999) begin
                    n_ovf = 1'b1;
                    n_neg = 1'b1;
                    n_mag = ssnf_pkg::SAT_NEG;
                end else if (i_number < 17'sd0) begin
                    n_neg = 1'b1;
                    n_mag = n_negated[ssnf_pkg::BIN_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    // segment pattern of the digit being written
    always_comb begin
        n_nib  = (r_kind == ssnf_pkg::KIND_HEX) ? r_bcd[3:0]
                                                : r_bcd[ssnf_pkg::BCD_W-1 -: 4];
        n_lead = r_lead;
        n_seg  = 8'h00;
        unique case (r_kind)
            ssnf_pkg::KIND_HEX: begin
                n_seg = ssnf_pkg::seg_of(n_nib);
            end
            ssnf_pkg::KIND_UDEC: begin
                if (n_nib != 4'd0 || r_pos == 2'd0) begin
                    n_lead = 1'b1;
                end
                n_seg = n_lead ? ssnf_pkg::seg_of(n_nib) : 8'h00;
            end
            ssnf_pkg::KIND_SDEC: begin
                if (r_neg && r_pos == 2'd3) begin
                    n_seg = r_minus;
                end else begin
                    if (n_nib != 4'd0) begin
                        n_lead = 1'b1;
                    end
                    if (r_pos != 2'd0 && {1'b0, r_pos} == r_dot) begin
                        n_lead = 1'b1;
                        n_seg  = ssnf_pkg::seg_of(n_nib) | ssnf_pkg::DOT_BIT;
                    end else if (n_lead || r_pos == 2'd0) begin
                        n_seg = ssnf_pkg::seg_of(n_nib);
                    end
                end
            end
            default: begin
                n_seg = 8'h00;
            end
        endcase
        n_last = (r_kind == ssnf_pkg::KIND_HEX) ? (r_pos == 2'd3) : (r_pos == 2'd0);
    end

    // sequencer with registered write outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_minus <= ssnf_pkg::MINUS_RST;
        end else begin
            if (i_minus_we) begin
                r_minus <= i_minus_pattern;
            end
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_kind <= i_kind;
                        r_dot  <= i_dot_position;
                        r_neg  <= n_neg;
                        r_ovf  <= n_ovf;
                        r_lead <= 1'b0;
                        r_bin  <= n_mag;
                        r_cnt  <= 4'(ssnf_pkg::BIN_W - 1);
                        unique case (i_kind)
                            ssnf_pkg::KIND_HEX: begin
                                r_bcd   <= i_number[ssnf_pkg::BCD_W-1:0];
                                r_pos   <= 2'd0;
                                r_state <= S_OUT;
                            end
                            ssnf_pkg::KIND_BLANK: begin
                                r_bcd   <= '0;
                                r_pos   <= 2'd3;
                                r_state <= S_OUT;
                            end
                            default: begin
                                r_bcd   <= '0;
                                r_pos   <= 2'd3;
                                r_state <= S_CONV;
                            end
                        endcase
                    end
                end
                S_CONV: begin
                    // one binary bit into the bcd register per cycle
                    r_bcd <= {n_dab[ssnf_pkg::BCD_W-2:0], r_bin[ssnf_pkg::BIN_W-1]};
                    r_bin <= {r_bin[ssnf_pkg::BIN_W-2:0], 1'b0};
                    r_cnt <= r_cnt - 4'd1;
                    if (r_cnt == 4'd0) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // one digit out per cycle
                    r_valid   <= 1'b1;
                    r_out_pos <= r_pos;
                    r_seg     <= n_seg;
                    r_last    <= n_last;
                    r_out_ovf <= r_ovf;
                    r_lead    <= n_lead;
                    if (r_kind == ssnf_pkg::KIND_HEX) begin
                        r_bcd <= {4'd0, r_bcd[ssnf_pkg::BCD_W-1:4]};
                        r_pos <= r_pos + 2'd1;
                    end else begin
                        r_bcd <= {r_bcd[ssnf_pkg::BCD_W-5:0], 4'd0};
                        r_pos <= r_pos - 2'd1;
                    end
                    if (n_last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid          = r_valid;
    assign o_digit_position = r_out_pos;
    assign o_segments       = r_seg;
    assign o_last           = r_last;
    assign o_overflow       = r_out_ovf;

    // checks
    `include "seven_segment_number_formatter_defines.svh"

    `SSNF_ASSERT(a_accept_busy, w_accept |=> busy, "accepted request did not set busy")
    `SSNF_ASSERT(a_writes_run, o_valid && !o_last |=> o_valid, "gap inside a write burst")
    `SSNF_ASSERT(a_last_ends, o_valid && o_last |=> !o_valid, "write after the last one")
    `SSNF_ASSERT(a_ovf_stable, o_valid && !o_last |=> $stable(o_overflow), "overflow changed within a burst")
    `SSNF_ASSERT(a_valid_in_out, o_valid && !o_last |-> r_state == S_OUT, "write burst outside the output state")

endmodule

### verif/seven_segment_number_formatter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_number_formatter_checker
// watches the request and display-write channels of the number formatter,
// predicts the four digit writes of each request and compares every strobed
// write against the oldest one due
// ----------------------------------------------------------------------------
module seven_segment_number_formatter_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_minus_we,
    input  logic [7:0]         i_minus_pattern,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic [1:0]         i_kind,
    input  logic signed [16:0] i_number,
    input  logic [2:0]         i_dot_position,
    input  logic               i_valid,
    input  logic [1:0]         i_digit_position,
    input  logic [7:0]         i_segments,
    input  logic               i_last,
    input  logic               i_overflow,
    output int                 o_errors,
    output int                 o_pending
);

    // one display write as the block should produce it
    typedef struct packed {
        logic [1:0] pos;
        logic [7:0] seg;
        logic       last;
        logic       ovf;
    } t_digit_write;

    // glyphs 0-F, glyph n in bits [8n+7:8n]
    localparam logic [127:0] GLYPHS = {
        8'h71, 8'h79, 8'h5e, 8'h39, 8'h7c, 8'h77, 8'h6f, 8'h7f,
        8'h07, 8'h7d, 8'h6d, 8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f
    };

    t_digit_write digit_writes_due[$];
    logic [7:0]   minus_copy;
    int           error_count;
    int           pending_count;

    assign o_errors  = error_count;
    assign o_pending = pending_count;

    function automatic logic [7:0] glyph(input int value);
        return GLYPHS[value*8 +: 8];
    endfunction

    function automatic int weight(input int d);
        int w;
        w = 1;
        for (int k = 0; k < d; k++) begin
            w = w * 10;
        end
        return w;
    endfunction

    function automatic void queue_write(input int pos, input logic [7:0] seg,
                                        input logic last, input logic ovf);
        t_digit_write w;
        w.pos  = pos[1:0];
        w.seg  = seg;
        w.last = last;
        w.ovf  = ovf;
        digit_writes_due.push_back(w);
    endfunction

    // expected digit writes of one request, in display order
    function automatic void format_request(input logic [1:0] kind,
                                           input logic signed [16:0] num,
                                           input logic [2:0] dot);
        int         val;
        int         mag;
        int         dv;
        int         top;
        logic       ovf;
        logic       neg;
        logic       lead;
        logic [7:0] seg;
        ovf  = 1'b0;
        lead = 1'b0;
        case (kind)
            ssnf_pkg::KIND_HEX: begin
                for (int d = 0; d < 4; d++) begin
                    queue_write(d, glyph(int'(num[4*d +: 4])), d == 3, 1'b0);
                end
            end
            ssnf_pkg::KIND_UDEC: begin
                val = int'($unsigned(num));
                if (val > 9999) begin
                    val = 9999;
                    ovf = 1'b1;
                end
                for (int d = 3; d >= 0; d--) begin
                    dv = (val / weight(d)) % 10;
                    if (dv != 0 || d == 0) lead = 1'b1;
                    queue_write(d, lead ? glyph(dv) : 8'h00, d == 0, ovf);
                end
            end
            ssnf_pkg::KIND_SDEC: begin
                val = int'(num);
                if (val > 9999) begin
                    val = 9999;
                    ovf = 1'b1;
                end
                if (val < -999) begin
                    val = -999;
                    ovf = 1'b1;
                end
                neg = val < 0;
                mag = neg ? -val : val;
                top = 3;
                // sign takes the leftmost digit, so no dot can land there
                if (neg) begin
                    queue_write(3, minus_copy, 1'b0, ovf);
                    top = 2;
                end
                for (int d = top; d >= 0; d--) begin
                    dv = (mag / weight(d)) % 10;
                    if (dv != 0) lead = 1'b1;
                    if (d != 0 && d == int'(dot)) begin
                        lead = 1'b1;
                        seg  = glyph(dv) | ssnf_pkg::DOT_BIT;
                    end else if (lead || d == 0) begin
                        seg = glyph(dv);
                    end else begin
                        seg = 8'h00;
                    end
                    queue_write(d, seg, d == 0, ovf);
                end
            end
            default: begin
                for (int d = 3; d >= 0; d--) begin
                    queue_write(d, 8'h00, d == 0, 1'b0);
                end
            end
        endcase
    endfunction

    // one line per bad write; only the first hundred are printed
    task automatic report_mismatch(input string msg);
        if (error_count < 100) $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    // compare strobed writes, then take in new requests and register writes
    always @(posedge i_clk) begin
        t_digit_write want;
        if (!i_rst_n) begin
            minus_copy = ssnf_pkg::MINUS_RST;
            digit_writes_due.delete();
            error_count = 0;
        end else begin
            if (i_valid) begin
                if (digit_writes_due.size() == 0) begin
                    report_mismatch($sformatf("write pos=%0d seg=%02h with none due",
                                              i_digit_position, i_segments));
                end else begin
                    want = digit_writes_due.pop_front();
                    if (i_digit_position !== want.pos || i_segments !== want.seg ||
                        i_last !== want.last || i_overflow !== want.ovf) begin
                        report_mismatch($sformatf(
                            "pos %0d/%0d seg %02h/%02h last %b/%b ovf %b/%b (got/want)",
                            i_digit_position, want.pos, i_segments, want.seg,
                            i_last, want.last, i_overflow, want.ovf));
                    end
                end
            end
            if (i_start && !i_busy) begin
                format_request(i_kind, i_number, i_dot_position);
            end
            if (i_minus_we) begin
                minus_copy = i_minus_pattern;
            end
        end
        pending_count = digit_writes_due.size();
    end

    initial begin
        error_count   = 0;
        pending_count = 0;
        minus_copy    = ssnf_pkg::MINUS_RST;
    end

endmodule

### verif/seven_segment_number_formatter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_number_formatter_tb
// drives number requests into the formatter: a directed set over each format,
// saturation, blanking, dot and sign, then random phases with different minus
// patterns and sender idle rates; the checker beside the block compares
// ----------------------------------------------------------------------------
module seven_segment_number_formatter_tb;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 24;
    localparam int PHASE_ITEMS   = 59;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_minus_we;
    logic [7:0]         i_minus_pattern;
    logic               start;
    logic               busy;
    logic [1:0]         i_kind;
    logic signed [16:0] i_number;
    logic [2:0]         i_dot_position;
    logic               o_valid;
    logic [1:0]         o_digit_position;
    logic [7:0]         o_segments;
    logic               o_last;
    logic               o_overflow;

    int error_count;
    int writes_pending;
    int cycle_count;
    int idle_pct;

    seven_segment_number_formatter i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_minus_we       (i_minus_we),
        .i_minus_pattern  (i_minus_pattern),
        .start            (start),
        .busy             (busy),
        .i_kind           (i_kind),
        .i_number         (i_number),
        .i_dot_position   (i_dot_position),
        .o_valid          (o_valid),
        .o_digit_position (o_digit_position),
        .o_segments       (o_segments),
        .o_last           (o_last),
        .o_overflow       (o_overflow)
    );

    seven_segment_number_formatter_checker u_write_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_minus_we       (i_minus_we),
        .i_minus_pattern  (i_minus_pattern),
        .i_start          (start),
        .i_busy           (busy),
        .i_kind           (i_kind),
        .i_number         (i_number),
        .i_dot_position   (i_dot_position),
        .i_valid          (o_valid),
        .i_digit_position (o_digit_position),
        .i_segments       (o_segments),
        .i_last           (o_last),
        .i_overflow       (o_overflow),
        .o_errors         (error_count),
        .o_pending        (writes_pending)
    );

    // 8 ns clock
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // run limit
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // present one request, hold it until taken, return at the next falling edge
    task automatic send_request(input logic [1:0] kind, input int num,
                                input logic [2:0] dot);
        while ($urandom_range(99) < idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start          = 1'b1;
        i_kind         = kind;
        i_number       = 17'(num);
        i_dot_position = dot;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    // stop sending and let every due write come out, then let the block settle
    task automatic wait_drained();
        start = 1'b0;
        while (writes_pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // minus pattern write, only while idle
    task automatic write_minus(input logic [7:0] value);
        i_minus_we      = 1'b1;
        i_minus_pattern = value;
        @(negedge i_clk);
        i_minus_we = 1'b0;
    endtask

    // random value with weight on small numbers and the saturation edges
    function automatic int pick_number();
        int n;
        case ($urandom_range(9)) inside
            [0:1]:   n = int'($urandom_range(20));
            [2:3]:   n = int'($urandom_range(9999));
            4:       n = int'($urandom_range(10010, 9990));
            5:       n = -int'($urandom_range(1010, 990));
            6:       n = int'($urandom_range(40)) - 20;
            default: n = int'($urandom_range(17'h1ffff));
        endcase
        return n;
    endfunction

    function automatic logic [1:0] pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 20) return ssnf_pkg::KIND_HEX;
        if (r < 50) return ssnf_pkg::KIND_UDEC;
        if (r < 95) return ssnf_pkg::KIND_SDEC;
        return ssnf_pkg::KIND_BLANK;
    endfunction

    initial begin
        i_rst_n         = 1'b0;
        i_minus_we      = 1'b0;
        i_minus_pattern = 8'h00;
        start           = 1'b0;
        i_kind          = ssnf_pkg::KIND_HEX;
        i_number        = '0;
        i_dot_position  = 3'd0;
        idle_pct        = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed set, minus pattern at its reset value
        send_request(ssnf_pkg::KIND_HEX,  0,        3'd0);
        send_request(ssnf_pkg::KIND_HEX,  'hffff,   3'd7);
        send_request(ssnf_pkg::KIND_HEX,  'h1abcd,  3'd2);
        send_request(ssnf_pkg::KIND_HEX,  'h1234,   3'd0);
        send_request(ssnf_pkg::KIND_UDEC, 0,        3'd0);
        send_request(ssnf_pkg::KIND_UDEC, 7,        3'd3);
        send_request(ssnf_pkg::KIND_UDEC, 100,      3'd2);
        send_request(ssnf_pkg::KIND_UDEC, 9999,     3'd0);
        send_request(ssnf_pkg::KIND_UDEC, 10000,    3'd0);
        send_request(ssnf_pkg::KIND_UDEC, -1,       3'd0);
        send_request(ssnf_pkg::KIND_SDEC, 0,        3'd0);
        send_request(ssnf_pkg::KIND_SDEC, 0,        3'd2);
        send_request(ssnf_pkg::KIND_SDEC, 0,        3'd3);
        send_request(ssnf_pkg::KIND_SDEC, 42,       3'd1);
        send_request(ssnf_pkg::KIND_SDEC, 5,        3'd3);
        send_request(ssnf_pkg::KIND_SDEC, 1234,     3'd5);
        send_request(ssnf_pkg::KIND_SDEC, 9999,     3'd0);
        send_request(ssnf_pkg::KIND_SDEC, 10000,    3'd1);
        send_request(ssnf_pkg::KIND_SDEC, 65535,    3'd0);
        send_request(ssnf_pkg::KIND_SDEC, -1,       3'd0);
        send_request(ssnf_pkg::KIND_SDEC, -5,       3'd3);
        send_request(ssnf_pkg::KIND_SDEC, -5,       3'd2);
        send_request(ssnf_pkg::KIND_SDEC, -999,     3'd1);
        send_request(ssnf_pkg::KIND_SDEC, -1000,    3'd0);
        send_request(ssnf_pkg::KIND_SDEC, -65536,   3'd7);
        send_request(ssnf_pkg::KIND_BLANK, 'h1ffff, 3'd7);
        wait_drained();

        // random phases: minus pattern and sender idle rate per phase
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    write_minus(8'hff);
                    idle_pct = 0;
                end
                1: begin
                    write_minus(8'h00);
                    idle_pct = 49;
                end
                2: begin
                    write_minus(8'($urandom_range(255)));
                    idle_pct = 0;
                end
                default: begin
                    write_minus(8'($urandom_range(255)));
                    idle_pct = 25;
                end
            endcase
            repeat (PHASE_ITEMS) begin
                send_request(pick_kind(), pick_number(), 3'($urandom_range(7)));
            end
            wait_drained();
        end

        if (error_count == 0 && writes_pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/ssnf_pkg.sv
rtl/seven_segment_number_formatter.sv
verif/seven_segment_number_formatter_checker.sv
verif/seven_segment_number_formatter_tb.sv
